// ===== hdl/siim_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// siim_pkg: shared types and constants for the interval insert/merge block
// Field widths, register indexes and the job record passed front to back.
// ----------------------------------------------------------------------------
package siim_pkg;

  localparam int OUT_W         = 32;  // width of every interval bound port
  localparam int CFG_IDX_W     = 2;
  localparam int CFG_DATA_W    = 32;
  localparam int COORD_BITS_DF = 32;
  localparam int QUEUE_DEPTH_DF = 4;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_NEW_START = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_NEW_END   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_INS_EN    = 2'd2;

  // one-hot phase of the new interval within the current list
  typedef enum logic [2:0] {
    PH_OPEN   = 3'b001,  // new interval not placed yet
    PH_MERGE  = 3'b010,  // merging overlapping inputs into it
    PH_PLACED = 3'b100   // already emitted
  } phase_t;

  // results caused by one input item: one or two intervals
  typedef struct packed {
    logic [1:0]       cnt;   // 1 or 2
    logic             last;  // item closed the list
    logic [OUT_W-1:0] a_lo;
    logic [OUT_W-1:0] a_hi;
    logic [OUT_W-1:0] b_lo;
    logic [OUT_W-1:0] b_hi;
  } job_t;

endpackage

// ===== hdl/siim_front.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// siim_front: classify incoming intervals against the new interval
// Holds configuration and merge state, turns each item with results into a job record.
// ----------------------------------------------------------------------------
module siim_front #(
  parameter int COORD_BITS = siim_pkg::COORD_BITS_DF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            cfg_we,
  input  logic [siim_pkg::CFG_IDX_W-1:0]  cfg_idx,
  input  logic [siim_pkg::CFG_DATA_W-1:0] cfg_wdata,
  input  logic                            in_push,
  input  logic [siim_pkg::OUT_W-1:0]      in_lo,
  input  logic [siim_pkg::OUT_W-1:0]      in_hi,
  input  logic                            in_list_end,
  input  logic                            in_no_interval,
  input  logic                            q_full,
  output logic                            in_full,
  output logic                            q_push,
  output siim_pkg::job_t                  q_job
);

  localparam int CW = (COORD_BITS < siim_pkg::OUT_W) ? COORD_BITS : siim_pkg::OUT_W;

  logic [siim_pkg::OUT_W-1:0] new_start_r, new_end_r;
  logic                       ins_en_r;
  siim_pkg::phase_t           phase_r, phase_nxt;
  logic [CW-1:0]              mlo_r, mlo_nxt, mhi_r, mhi_nxt;

  logic [CW-1:0] lo, hi, ns, ne;
  logic          accept;
  logic [1:0]    cnt;
  logic [CW-1:0] r_lo [2];
  logic [CW-1:0] r_hi [2];

  assign lo      = in_lo[CW-1:0];
  assign hi      = in_hi[CW-1:0];
  assign ns      = new_start_r[CW-1:0];
  assign ne      = (new_end_r[CW-1:0] < ns) ? ns : new_end_r[CW-1:0];
  assign in_full = q_full;
  assign accept  = in_push && !q_full;

  always_comb begin
    cnt       = 2'd0;
    r_lo[0]   = '0;
    r_hi[0]   = '0;
    r_lo[1]   = '0;
    r_hi[1]   = '0;
    phase_nxt = phase_r;
    mlo_nxt   = mlo_r;
    mhi_nxt   = mhi_r;
    if (!ins_en_r) begin
      if (!in_no_interval) begin
        r_lo[0] = lo;
        r_hi[0] = hi;
        cnt     = 2'd1;
      end
      if (in_list_end) begin
        phase_nxt = siim_pkg::PH_OPEN;
      end
    end else begin
      if (!in_no_interval) begin
        case (phase_r)
          siim_pkg::PH_OPEN: begin
            if (hi < ns) begin
              r_lo[0] = lo;
              r_hi[0] = hi;
              cnt     = 2'd1;
            end else if (lo > ne) begin
              r_lo[0]   = ns;
              r_hi[0]   = ne;
              r_lo[1]   = lo;
              r_hi[1]   = hi;
              cnt       = 2'd2;
              phase_nxt = siim_pkg::PH_PLACED;
            end else begin
              mlo_nxt   = (lo < ns) ? lo : ns;
              mhi_nxt   = (hi > ne) ? hi : ne;
              phase_nxt = siim_pkg::PH_MERGE;
            end
          end
          siim_pkg::PH_MERGE: begin
            if (lo > mhi_r) begin
              r_lo[0]   = mlo_r;
              r_hi[0]   = mhi_r;
              r_lo[1]   = lo;
              r_hi[1]   = hi;
              cnt       = 2'd2;
              phase_nxt = siim_pkg::PH_PLACED;
            end else begin
              if (lo < mlo_r) mlo_nxt = lo;
              if (hi > mhi_r) mhi_nxt = hi;
            end
          end
          default: begin
            r_lo[0] = lo;
            r_hi[0] = hi;
            cnt     = 2'd1;
          end
        endcase
      end
      if (in_list_end) begin
        // flush whatever is still pending
        if (phase_nxt == siim_pkg::PH_OPEN) begin
          r_lo[cnt[0]] = ns;
          r_hi[cnt[0]] = ne;
          cnt          = cnt + 2'd1;
        end else if (phase_nxt == siim_pkg::PH_MERGE) begin
          r_lo[cnt[0]] = mlo_nxt;
          r_hi[cnt[0]] = mhi_nxt;
          cnt          = cnt + 2'd1;
        end
        phase_nxt = siim_pkg::PH_OPEN;
      end
    end
  end

  assign q_push     = accept && (cnt != 2'd0);
  assign q_job.cnt  = cnt;
  assign q_job.last = in_list_end;
  assign q_job.a_lo = siim_pkg::OUT_W'(r_lo[0]);
  assign q_job.a_hi = siim_pkg::OUT_W'(r_hi[0]);
  assign q_job.b_lo = siim_pkg::OUT_W'(r_lo[1]);
  assign q_job.b_hi = siim_pkg::OUT_W'(r_hi[1]);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      new_start_r <= '0;
      new_end_r   <= '0;
      ins_en_r    <= 1'b1;
      phase_r     <= siim_pkg::PH_OPEN;
      mlo_r       <= '0;
      mhi_r       <= '0;
    end else begin
      if (cfg_we) begin
        case (cfg_idx)
          siim_pkg::REG_NEW_START: new_start_r <= cfg_wdata;
          siim_pkg::REG_NEW_END:   new_end_r   <= cfg_wdata;
          siim_pkg::REG_INS_EN:    ins_en_r    <= cfg_wdata[0];
          default: ;
        endcase
      end
      if (accept) begin
        phase_r <= phase_nxt;
        mlo_r   <= mlo_nxt;
        mhi_r   <= mhi_nxt;
      end
    end
  end

endmodule

// ===== hdl/siim_queue.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// siim_queue: job queue between front and back
// Small circular buffer of job records with first-word fall-through head.
// ----------------------------------------------------------------------------
module siim_queue #(
  parameter int QUEUE_DEPTH = siim_pkg::QUEUE_DEPTH_DF
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push,
  input  siim_pkg::job_t push_job,
  output logic           full,
  input  logic           pop,
  output siim_pkg::job_t head,
  output logic           empty
);

  localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  siim_pkg::job_t   mem [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [CNT_W-1:0] count_r;
  logic             do_push, do_pop;

  assign full    = (count_r == CNT_W'(QUEUE_DEPTH));
  assign empty   = (count_r == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign head    = mem[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (do_push) mem[wr_ptr_r] <= push_job;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= (wr_ptr_r == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_r <= (rd_ptr_r == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
      end
      case ({do_push, do_pop})
        2'b10:   count_r <= count_r + 1'b1;
        2'b01:   count_r <= count_r - 1'b1;
        default: ;
      endcase
    end
  end

endmodule

// ===== hdl/siim_back.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// siim_back: expand jobs into result beats
// Walks the one or two intervals of the head job into an output register.
// ----------------------------------------------------------------------------
module siim_back (
  input  logic                       clk,
  input  logic                       rst_n,
  input  siim_pkg::job_t             head,
  input  logic                       q_empty,
  output logic                       q_pop,
  output logic                       out_empty,
  input  logic                       out_pop,
  output logic [siim_pkg::OUT_W-1:0] out_lo,
  output logic [siim_pkg::OUT_W-1:0] out_hi,
  output logic                       out_run_last,
  output logic                       out_list_done
);

  logic                       vld_r;
  logic                       idx_r, idx_nxt;
  logic [siim_pkg::OUT_W-1:0] lo_r, hi_r;
  logic                       run_last_r, done_r;
  logic                       load, final_beat;

  assign load       = !q_empty && (!vld_r || out_pop);
  assign final_beat = idx_r || (head.cnt == 2'd1);
  assign q_pop      = load && final_beat;
  assign idx_nxt    = load ? !final_beat : idx_r;

  assign out_empty     = !vld_r;
  assign out_lo        = lo_r;
  assign out_hi        = hi_r;
  assign out_run_last  = run_last_r;
  assign out_list_done = done_r;

  always_ff @(posedge clk) begin
    if (load) begin
      lo_r       <= idx_r ? head.b_lo : head.a_lo;
      hi_r       <= idx_r ? head.b_hi : head.a_hi;
      run_last_r <= final_beat;
      done_r     <= final_beat && head.last;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
      idx_r <= 1'b0;
    end else begin
      idx_r <= idx_nxt;
      if (load) begin
        vld_r <= 1'b1;
      end else if (out_pop) begin
        vld_r <= 1'b0;
      end
    end
  end

endmodule

// ===== hdl/sorted_interval_insert_merge.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sorted_interval_insert_merge: insert one interval into a sorted list
// Streams sorted disjoint closed intervals, places a configured interval in
// order and merges every input interval that overlaps it, when insertion is enabled.
// ----------------------------------------------------------------------------
//
//  channel   handshake            payload
//  -------   -------------------  ------------------------------------------
//  input     in_push / in_full    in_lo, in_hi, in_list_end, in_no_interval
//  result    out_pop / out_empty  out_lo, out_hi, out_run_last, out_list_done
//  config    cfg_we               cfg_idx, cfg_wdata (no wait, no read-back)
//
// An item is classified in the cycle it is accepted; one item per cycle is
// taken while the job queue has room. The back end issues one result beat
// per cycle while out_pop drains the output register, so an item with two
// results holds the output for both beats; the queue absorbs that. Results
// pass through the queue memory, then the output register. Reset (rst_n
// low, synchronous) empties the queue and output register and restores the
// register defaults. A stalled result side fills the queue, then raises in_full.
// ----------------------------------------------------------------------------
module sorted_interval_insert_merge #(
  parameter int COORD_BITS  = siim_pkg::COORD_BITS_DF,
  parameter int QUEUE_DEPTH = siim_pkg::QUEUE_DEPTH_DF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  // configuration
  input  logic                            cfg_we,
  input  logic [siim_pkg::CFG_IDX_W-1:0]  cfg_idx,
  input  logic [siim_pkg::CFG_DATA_W-1:0] cfg_wdata,
  // input intervals
  input  logic                            in_push,
  output logic                            in_full,
  input  logic [siim_pkg::OUT_W-1:0]      in_lo,
  input  logic [siim_pkg::OUT_W-1:0]      in_hi,
  input  logic                            in_list_end,
  input  logic                            in_no_interval,
  // result intervals
  output logic                            out_empty,
  input  logic                            out_pop,
  output logic [siim_pkg::OUT_W-1:0]      out_lo,
  output logic [siim_pkg::OUT_W-1:0]      out_hi,
  output logic                            out_run_last,
  output logic                            out_list_done
);

  // jobs from front to back
  siim_pkg::job_t push_job, head_job;
  logic           q_push, q_full, q_pop, q_empty;

  // Front: hold config and merge state, classify each beat into a job.
  // Items that cause no result are consumed without a queue entry.
  siim_front #(
    .COORD_BITS (COORD_BITS)
  ) u_front (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_we         (cfg_we),
    .cfg_idx        (cfg_idx),
    .cfg_wdata      (cfg_wdata),
    .in_push        (in_push),
    .in_lo          (in_lo),
    .in_hi          (in_hi),
    .in_list_end    (in_list_end),
    .in_no_interval (in_no_interval),
    .q_full         (q_full),
    .in_full        (in_full),
    .q_push         (q_push),
    .q_job          (push_job)
  );

  // Queue: decouple classification from result delivery.
  siim_queue #(
    .QUEUE_DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (q_push),
    .push_job (push_job),
    .full     (q_full),
    .pop      (q_pop),
    .head     (head_job),
    .empty    (q_empty)
  );

  // Back: advance through each job's intervals into the output register.
  siim_back u_back (
    .clk           (clk),
    .rst_n         (rst_n),
    .head          (head_job),
    .q_empty       (q_empty),
    .q_pop         (q_pop),
    .out_empty     (out_empty),
    .out_pop       (out_pop),
    .out_lo        (out_lo),
    .out_hi        (out_hi),
    .out_run_last  (out_run_last),
    .out_list_done (out_list_done)
  );

endmodule
